// ----- sv/cbd_pkg.sv -----
`timescale 1ns / 1ps

package cbd_pkg;

  // Classified input byte, passed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
    logic       is_semi;
    logic       is_x;
    logic       is_hex;
    logic [3:0] hex_val;
  } cbd_item_t;

  // One result beat; out_byte sits in the lowest bits.
  typedef struct packed {
    logic [1:0] error_code;
    logic       body_done;
    logic       out_valid;
    logic [7:0] out_byte;
  } cbd_result_t;

  typedef enum logic [5:0] {
    PH_SIZE  = 6'b000001,
    PH_DATA  = 6'b000010,
    PH_CR    = 6'b000100,
    PH_LF    = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_DONE  = 6'b100000
  } cbd_phase_t;

  typedef enum logic [6:0] {
    SP_LEAD   = 7'b0000001,
    SP_ZERO   = 7'b0000010,
    SP_PREFIX = 7'b0000100,
    SP_DIGITS = 7'b0001000,
    SP_TRAIL  = 7'b0010000,
    SP_EXT    = 7'b0100000,
    SP_BAD    = 7'b1000000
  } cbd_step_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_LINE_LONG = 2'd1;
  localparam logic [1:0] ERR_BAD_SIZE  = 2'd2;
  localparam logic [1:0] ERR_NO_CRLF   = 2'd3;

  localparam logic [1:0] CFG_CHUNKED_MODE = 2'd0;
  localparam logic [1:0] CFG_LENGTH_KNOWN = 2'd1;
  localparam logic [1:0] CFG_BODY_LENGTH  = 2'd2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

endpackage

// ----- sv/cbd_front.sv -----
`timescale 1ns / 1ps

module cbd_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cbd_pkg::IN_DATA_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic                          queue_full,
  output logic                          push,
  output cbd_pkg::cbd_item_t            push_item
);
  import cbd_pkg::*;

  logic [7:0] c;
  logic       is_digit;
  logic       is_lower;
  logic       is_upper;

  assign c        = in_tdata[7:0];
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_lower = (c >= 8'h61) && (c <= 8'h66);
  assign is_upper = (c >= 8'h41) && (c <= 8'h46);

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;

  always_comb begin
    push_item.data     = c;
    push_item.is_cr    = (c == CH_CR);
    push_item.is_lf    = (c == CH_LF);
    push_item.is_blank = (c == CH_SP) || (c == CH_TAB);
    push_item.is_semi  = (c == CH_SEMI);
    push_item.is_x     = (c == CH_LX) || (c == CH_UX);
    push_item.is_hex   = is_digit || is_lower || is_upper;
    push_item.hex_val  = is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);
  end

endmodule

// ----- sv/cbd_queue.sv -----
`timescale 1ns / 1ps

module cbd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cbd_pkg::cbd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output cbd_pkg::cbd_item_t pop_item
);
  import cbd_pkg::*;

  cbd_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/cbd_back.sv -----
`timescale 1ns / 1ps

module cbd_back #(
  parameter int MAX_LINE  = 384,
  parameter int SIZE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           item_valid,
  input  cbd_pkg::cbd_item_t             item,
  output logic                           item_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cbd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cbd_pkg::*;

  localparam int LL_W = $clog2(MAX_LINE + 1);

  logic                  chunked_r, chunked_nxt;
  logic                  known_r, known_nxt;
  logic [CFG_DATA_W-1:0] body_len_r, body_len_nxt;
  logic [CFG_DATA_W-1:0] len_left_r, len_left_nxt;
  cbd_phase_t            phase_r, phase_nxt;
  cbd_step_t             step_r, step_nxt;
  logic [SIZE_BITS-1:0]  acc_r, acc_nxt;
  logic [LL_W-1:0]       line_len_r, line_len_nxt;
  logic [SIZE_BITS-1:0]  chunk_left_r, chunk_left_nxt;
  logic [1:0]            sticky_r, sticky_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cbd_result_t           out_data_r, out_data_nxt;

  cbd_step_t             step_parse;
  logic [SIZE_BITS-1:0]  acc_parse;
  logic                  take;
  logic                  line_full;
  logic                  size_ok;
  cbd_result_t           res;

  assign take       = item_valid && (!out_valid_r || out_tready);
  assign item_pop   = take;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign line_full  = (line_len_r >= LL_W'(MAX_LINE));
  assign size_ok    = (step_r == SP_ZERO) || (step_r == SP_DIGITS) ||
                      (step_r == SP_TRAIL) || (step_r == SP_EXT);

  // Size line grammar, one character per beat.
  always_comb begin
    step_parse = step_r;
    acc_parse  = acc_r;
    priority if ((step_r == SP_BAD) || (step_r == SP_EXT)) begin
      step_parse = step_r;
    end else if (item.is_blank) begin
      if ((step_r == SP_ZERO) || (step_r == SP_DIGITS)) begin
        step_parse = SP_TRAIL;
      end else if (step_r == SP_PREFIX) begin
        step_parse = SP_BAD;
      end
    end else if (item.is_semi) begin
      step_parse = ((step_r == SP_ZERO) || (step_r == SP_DIGITS) || (step_r == SP_TRAIL)) ?
                   SP_EXT : SP_BAD;
    end else if (item.is_x && (step_r == SP_ZERO)) begin
      step_parse = SP_PREFIX;
    end else if (item.is_hex && (step_r != SP_TRAIL)) begin
      if (acc_r[SIZE_BITS-1 -: 4] != 4'd0) begin
        step_parse = SP_BAD;
      end else begin
        acc_parse  = {acc_r[SIZE_BITS-5:0], item.hex_val};
        step_parse = ((step_r == SP_LEAD) && (item.hex_val == 4'd0)) ? SP_ZERO : SP_DIGITS;
      end
    end else begin
      step_parse = SP_BAD;
    end
  end

  always_comb begin
    chunked_nxt    = chunked_r;
    known_nxt      = known_r;
    body_len_nxt   = body_len_r;
    len_left_nxt   = len_left_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    line_len_nxt   = line_len_r;
    chunk_left_nxt = chunk_left_r;
    sticky_nxt     = sticky_r;
    res            = '0;

    if (take) begin
      if (sticky_r != ERR_NONE) begin
        res.body_done = 1'b0;
      end else if (!chunked_r) begin
        if (known_r && (len_left_r == '0)) begin
          res.body_done = 1'b1;
        end else begin
          res.out_byte  = item.data;
          res.out_valid = 1'b1;
          if (known_r) begin
            len_left_nxt  = len_left_r - CFG_DATA_W'(1);
            res.body_done = (len_left_r == CFG_DATA_W'(1));
          end
        end
      end else begin
        unique case (phase_r)
          PH_DATA: begin
            res.out_byte  = item.data;
            res.out_valid = 1'b1;
            if (chunk_left_r != '0) begin
              chunk_left_nxt = chunk_left_r - SIZE_BITS'(1);
            end
            if (chunk_left_r[SIZE_BITS-1:1] == '0) begin
              phase_nxt = PH_CR;
            end
          end
          PH_CR: begin
            if (item.is_cr) begin
              phase_nxt = PH_LF;
            end else begin
              sticky_nxt = ERR_NO_CRLF;
            end
          end
          PH_LF: begin
            if (item.is_lf) begin
              phase_nxt    = PH_SIZE;
              line_len_nxt = '0;
              step_nxt     = SP_LEAD;
              acc_nxt      = '0;
            end else begin
              sticky_nxt = ERR_NO_CRLF;
            end
          end
          PH_SIZE: begin
            priority if (item.is_cr) begin
              phase_nxt = PH_SIZE;
            end else if (item.is_lf) begin
              if (size_ok) begin
                if (acc_r == '0) begin
                  phase_nxt = PH_TRAIL;
                end else begin
                  chunk_left_nxt = acc_r;
                  phase_nxt      = PH_DATA;
                end
                line_len_nxt = '0;
                step_nxt     = SP_LEAD;
                acc_nxt      = '0;
              end else begin
                sticky_nxt = ERR_BAD_SIZE;
              end
            end else if (line_full) begin
              sticky_nxt = ERR_LINE_LONG;
            end else begin
              line_len_nxt = line_len_r + LL_W'(1);
              step_nxt     = step_parse;
              acc_nxt      = acc_parse;
            end
          end
          PH_TRAIL: begin
            priority if (item.is_cr) begin
              phase_nxt = PH_TRAIL;
            end else if (item.is_lf) begin
              if (line_len_r == '0) begin
                phase_nxt = PH_DONE;
              end
              line_len_nxt = '0;
            end else if (line_full) begin
              phase_nxt = PH_DONE;
            end else begin
              line_len_nxt = line_len_r + LL_W'(1);
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
        res.body_done = (phase_nxt == PH_DONE) && (sticky_nxt == ERR_NONE);
      end
      res.error_code = sticky_nxt;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CHUNKED_MODE: chunked_nxt = cfg_wdata[0];
        CFG_LENGTH_KNOWN: known_nxt   = cfg_wdata[0];
        CFG_BODY_LENGTH: begin
          body_len_nxt = cfg_wdata;
          len_left_nxt = cfg_wdata;
        end
        default: chunked_nxt = chunked_r;
      endcase
    end

    out_valid_nxt = take ? 1'b1 : (out_valid_r && !out_tready);
    out_data_nxt  = take ? res : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_r    <= 1'b1;
      known_r      <= 1'b0;
      body_len_r   <= '0;
      len_left_r   <= '0;
      phase_r      <= PH_SIZE;
      step_r       <= SP_LEAD;
      acc_r        <= '0;
      line_len_r   <= '0;
      chunk_left_r <= '0;
      sticky_r     <= ERR_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      chunked_r    <= chunked_nxt;
      known_r      <= known_nxt;
      body_len_r   <= body_len_nxt;
      len_left_r   <= len_left_nxt;
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      acc_r        <= acc_nxt;
      line_len_r   <= line_len_nxt;
      chunk_left_r <= chunk_left_nxt;
      sticky_r     <= sticky_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.body_done |-> out_data_r.error_code == ERR_NONE)
    else $error("body_done reported together with an error");

  a_payload_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_valid |-> out_data_r.error_code == ERR_NONE)
    else $error("payload byte reported together with an error");

  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r != ERR_NONE |=> sticky_r == $past(sticky_r))
    else $error("held error changed");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LL_W'(MAX_LINE))
    else $error("line length beyond limit");

  a_body_len_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> body_len_r == $past(body_len_r))
    else $error("body length changed without a write");

endmodule

// ----- sv/http_chunked_body_decoder_core.sv -----
`timescale 1ns / 1ps
// A beat accepted at in_ is written into the queue, then taken by the back end and held in its
// output register, which presents it at out_ until out_tready is high.
// Throughput: one beat per cycle while the output register is empty or out_tready is high.
// A four-entry queue between classifier and back end absorbs short output stalls.
// Reset (rst_n low, synchronous) selects chunked mode, clears the queue, the parse state,
// the held error and the output valid flag; configuration registers return to their defaults.
module http_chunked_body_decoder_core #(
  parameter int MAX_LINE  = 384,
  parameter int SIZE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cbd_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] in_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_byte, [8] out_valid, [9] body_done, [11:10] error_code, [15:12] zero
  output logic [cbd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cbd_pkg::*;

  cbd_item_t push_item;
  cbd_item_t pop_item;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_not_empty;

  cbd_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  cbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .pop_item  (pop_item)
  );

  cbd_back #(
    .MAX_LINE  (MAX_LINE),
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (queue_not_empty),
    .item       (pop_item),
    .item_pop   (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
